/* design/tpdc_pkg.sv */
// ----------------------------------------------------------------------------
// tpdc_pkg
// Shared constants and types of the temperature PI duty controller.
// ----------------------------------------------------------------------------
package tpdc_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CURRENT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PREVIOUS = 2'd2;

  // field widths
  localparam int SETPOINT_W = 17;
  localparam int GAIN_W     = 24;
  localparam int DUTY_W     = 15;
  localparam int TEMP_W     = 17;
  localparam int ERR_W      = 19;
  localparam int OUT_W      = 56;

  // register reset values
  localparam logic [SETPOINT_W-1:0]    SETPOINT_RST      = 17'd19200;
  localparam logic signed [GAIN_W-1:0] GAIN_CURRENT_RST  = 24'sd708968;
  localparam logic signed [GAIN_W-1:0] GAIN_PREVIOUS_RST = -24'sd1180;

  // linearization, Q.24 degrees per full scale
  localparam logic [31:0] TC_SLOPE_Q24  = 32'd2485685874;
  localparam logic [31:0] AMB_SLOPE_Q24 = 32'd1842745839;

  // quotient width and the offset folded with rounding and bias
  localparam int          QUOT_W        = 34;
  localparam logic [QUOT_W-1:0] TEMP_BIAS_SUM =
    QUOT_W'((64'd16384 << 16) - 64'd871646164 + 64'd32768);
  localparam logic [ERR_W-1:0]  TEMP_BIAS_Q8  = 19'd16384;

  // drive
  localparam int          ACC_W     = 44;
  localparam logic signed [ACC_W-1:0] ROUND_Q16 = 44'sd32768;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 15'd25600;

  // configuration register bank
  typedef struct packed {
    logic [SETPOINT_W-1:0]    setpoint;
    logic signed [GAIN_W-1:0] gain_current;
    logic signed [GAIN_W-1:0] gain_previous;
  } cfg_regs_t;

endpackage

/* design/tpdc_front.sv */
// ----------------------------------------------------------------------------
// tpdc_front
// Input stage: takes the code pair transfer, strips byte padding and holds
// the pair until the queue takes it.
// ----------------------------------------------------------------------------
module tpdc_front #(
  parameter int CODE_BITS = 10,
  localparam int IN_W = ((2 * CODE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,
  output logic                     codes_valid,
  input  logic                     codes_ready,
  output logic [2*CODE_BITS-1:0]   codes
);

  // holding register is free when empty or being drained
  assign s_tready = !codes_valid || codes_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes_valid <= 1'b0;
    end else if (s_tready) begin
      codes_valid <= s_tvalid;
    end
  end

  // keep both codes, drop padding bits
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      codes <= s_tdata[2*CODE_BITS-1:0];
    end
  end

endmodule

/* design/tpdc_fifo.sv */
// ----------------------------------------------------------------------------
// tpdc_fifo
// Short queue between the input stage and the compute sequencer.
// ----------------------------------------------------------------------------
module tpdc_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/tpdc_div.sv */
// ----------------------------------------------------------------------------
// tpdc_div
// Division by the converter full scale 2^DIVISOR_W - 1: the high part of the
// running value is folded onto its low part a fixed number of times, then one
// final correction step.
// ----------------------------------------------------------------------------
module tpdc_div #(
  parameter int DIVIDEND_W = 43,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  // enough folds to bring any dividend below 2^DIVISOR_W
  localparam int FOLDS = (DIVIDEND_W - 3) / (DIVISOR_W - 1) + 2;
  localparam int CNT_W = $clog2(FOLDS + 1);
  localparam logic [DIVIDEND_W-1:0] FULL_SCALE = DIVIDEND_W'({DIVISOR_W{1'b1}});

  logic [DIVIDEND_W-1:0] rest;
  logic [DIVIDEND_W-1:0] quot;
  logic [DIVIDEND_W-1:0] high_part;
  logic [DIVIDEND_W-1:0] low_part;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;

  // h * 2^N + l = h * (2^N - 1) + (h + l)
  assign high_part = rest >> DIVISOR_W;
  assign low_part  = DIVIDEND_W'(rest[DIVISOR_W-1:0]);

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FOLDS);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // fold steps, then a remainder equal to the full scale adds one
  always_ff @(posedge clk) begin
    if (start) begin
      rest <= dividend;
      quot <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        quot <= quot + high_part;
        rest <= high_part + low_part;
      end else begin
        quot <= quot + DIVIDEND_W'(rest == FULL_SCALE);
      end
    end
  end

  assign quotient = quot;

endmodule

/* design/tpdc_back.sv */
// ----------------------------------------------------------------------------
// tpdc_back
// Compute sequencer: linearizes the code pair, forms the error, runs the
// velocity-form PI update with clamping and drives the result register.
// ----------------------------------------------------------------------------
module tpdc_back import tpdc_pkg::*; #(
  parameter int CODE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_regs_t              cfg,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [2*CODE_BITS-1:0] q_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata
);

  localparam int NUM_W  = CODE_BITS + 33;
  localparam int PROD_W = CODE_BITS + 32;
  localparam logic [CODE_BITS-1:0] CODE_FS = {CODE_BITS{1'b1}};
  localparam logic [NUM_W-1:0]     FS_HALF = NUM_W'(CODE_FS >> 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_MUL_T    = 11'b000_0000_0010,
    S_MUL_A    = 11'b000_0000_0100,
    S_ADD      = 11'b000_0000_1000,
    S_DIV_GO   = 11'b000_0001_0000,
    S_DIV_WAIT = 11'b000_0010_0000,
    S_TEMP     = 11'b000_0100_0000,
    S_MUL_C    = 11'b000_1000_0000,
    S_MUL_P    = 11'b001_0000_0000,
    S_SUM      = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CODE_BITS-1:0]    ct;
  logic [CODE_BITS-1:0]    ca;
  logic [PROD_W-1:0]       prod;
  logic [NUM_W-1:0]        num;
  logic [TEMP_W-1:0]       temp;
  logic signed [ERR_W-1:0] err;
  logic signed [42:0]      pc;
  logic signed [42:0]      pp;
  logic signed [ACC_W-1:0] acc;
  logic signed [ERR_W-1:0] last_error;
  logic [DUTY_W-1:0]       last_duty;

  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        quot;

  logic [QUOT_W-1:0]       biased;
  logic [ERR_W-1:0]        temp_wide;
  logic [TEMP_W-1:0]       temp_next;
  logic [ERR_W-1:0]        err_next;
  logic [28:0]             u_sum;
  logic [DUTY_W-1:0]       duty_next;
  logic                    out_free;

  assign q_ready   = (state == S_IDLE);
  assign div_start = (state == S_DIV_GO);
  assign out_free  = !m_tvalid || m_tready;

  tpdc_div #(
    .DIVIDEND_W (NUM_W),
    .DIVISOR_W  (CODE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .done     (div_done),
    .quotient (quot)
  );

  // temperature and error from the quotient
  always_comb begin
    biased    = quot[QUOT_W-1:0] + TEMP_BIAS_SUM;
    temp_wide = {1'b0, biased[QUOT_W-1:16]} - TEMP_BIAS_Q8;
    temp_next = temp_wide[TEMP_W-1:0];
    err_next  = {2'b00, cfg.setpoint} - {{(ERR_W - TEMP_W){temp_next[TEMP_W-1]}}, temp_next};
  end

  // rounded increment plus previous drive, clamped
  always_comb begin
    u_sum = {acc[ACC_W-1], acc[ACC_W-1:16]} + {14'b0, last_duty};
    if (u_sum[28]) begin
      duty_next = '0;
    end else if (u_sum > 29'(DUTY_MAX)) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = u_sum[DUTY_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (q_valid) state_next = S_MUL_T;
      S_MUL_T:    state_next = S_MUL_A;
      S_MUL_A:    state_next = S_ADD;
      S_ADD:      state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_next = S_TEMP;
      S_TEMP:     state_next = S_MUL_C;
      S_MUL_C:    state_next = S_MUL_P;
      S_MUL_P:    state_next = S_SUM;
      S_SUM:      state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ct <= q_data[CODE_BITS-1:0];
        ca <= q_data[2*CODE_BITS-1:CODE_BITS];
      end
      S_MUL_T: prod <= ct * TC_SLOPE_Q24;
      S_MUL_A: begin
        num  <= NUM_W'(prod) + FS_HALF;
        prod <= ca * AMB_SLOPE_Q24;
      end
      S_ADD:   num <= num + NUM_W'(prod);
      S_TEMP: begin
        temp <= temp_next;
        err  <= err_next;
      end
      S_MUL_C: pc  <= cfg.gain_current * err;
      S_MUL_P: pp  <= cfg.gain_previous * last_error;
      S_SUM:   acc <= ACC_W'(pc) + ACC_W'(pp) + ROUND_Q16;
      default: ;
    endcase
  end

  // loop state, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      last_duty  <= '0;
    end else if (state == S_DONE && out_free) begin
      last_error <= err;
      last_duty  <= duty_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {5'b0, err, temp, duty_next};
    end
  end

endmodule

/* design/temperature_pi_duty_controller.sv */
// ----------------------------------------------------------------------------
// temperature_pi_duty_controller
// Thermocouple plus ambient temperature measurement and PI duty control.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer carries a thermocouple code and an ambient
// sensor code. The block converts them into a measured temperature, forms the
// error against the setpoint, applies the velocity-form PI update to the
// previous drive and clamps the drive to 0..100 percent (Q.8).
// Output stream m_*: one result transfer per input transfer, in order.
// Config channel cfg_*: cfg_index selects setpoint, gain_current or
// gain_previous; cfg_ready is always high and an index beyond the register
// list is ignored. Write only while no item is in flight.
// Each item occupies the sequencer, which takes no new item until its result
// is in the result register; the division by the converter full scale runs
// FOLDS = (CODE_BITS + 30) / (CODE_BITS - 1) + 2 add steps. The sequencer
// sets the throughput.
// An input stage and a two-entry queue take new items while the sequencer
// works or while a result waits; when m_tready is low the result register
// holds and the sequencer waits in its last step.
// Reset (rst, synchronous) loads the register defaults, zeroes the stored
// error and drive and empties the queue.
// ----------------------------------------------------------------------------
module temperature_pi_duty_controller import tpdc_pkg::*; #(
  parameter int CODE_BITS = 10,
  localparam int IN_W = ((2 * CODE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // thermocouple_code, ambient_code, zero padding
  input  logic [IN_W-1:0]        s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // duty_percent[14:0], measured_temperature[31:15], control_error[50:32]
  output logic [OUT_W-1:0]       m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_regs_t              cfg;
  logic                   codes_valid;
  logic                   codes_ready;
  logic [2*CODE_BITS-1:0] codes;
  logic                   q_valid;
  logic                   q_ready;
  logic [2*CODE_BITS-1:0] q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint      <= SETPOINT_RST;
      cfg.gain_current  <= GAIN_CURRENT_RST;
      cfg.gain_previous <= GAIN_PREVIOUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:      cfg.setpoint      <= cfg_data[SETPOINT_W-1:0];
        REG_GAIN_CURRENT:  cfg.gain_current  <= cfg_data;
        REG_GAIN_PREVIOUS: cfg.gain_previous <= cfg_data;
        default: ;
      endcase
    end
  end

  tpdc_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .codes_valid (codes_valid),
    .codes_ready (codes_ready),
    .codes       (codes)
  );

  tpdc_fifo #(
    .WIDTH (2 * CODE_BITS),
    .DEPTH (2)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (codes_valid),
    .wr_ready (codes_ready),
    .wr_data  (codes),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  tpdc_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* tb/tpdc_loop_checker.sv */
// ----------------------------------------------------------------------------
// tpdc_loop_checker
// Watches the stream and config channels, predicts each duty result and
// compares it with what leaves the controller.
// ----------------------------------------------------------------------------
// Every accepted sample pair runs through a local copy of the linearization
// and the velocity-form PI update, with its own registers and loop state. The
// expected result is queued and checked field by field against the next
// result transfer. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module tpdc_loop_checker import tpdc_pkg::*; #(
  parameter int CODE_BITS = 10,
  parameter int IN_W      = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_W-1:0]       m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  // linearization constants, Q.24 degrees per full scale
  localparam u64_t   FULL_SCALE  = (u64_t'(1) << CODE_BITS) - 1;
  localparam u64_t   TC_Q24      = 64'd2485685874;
  localparam u64_t   AMB_Q24     = 64'd1842745839;
  localparam u64_t   OFFSET_Q24  = 64'd871646164;
  localparam u64_t   BIAS_Q8     = 64'd16384;
  localparam longint DUTY_FULL   = 25600;

  typedef struct packed {
    logic [DUTY_W-1:0]        duty;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ERR_W-1:0]  err;
  } loop_result_t;

  // register copies and loop state
  logic [SETPOINT_W-1:0]    setpoint_q8;
  logic signed [GAIN_W-1:0] gain_now;
  logic signed [GAIN_W-1:0] gain_prev;
  logic signed [ERR_W-1:0]  held_error;
  logic [DUTY_W-1:0]        prev_duty;

  loop_result_t expected_results[$];

  // one control step: measured temperature, error, clamped drive
  function automatic loop_result_t duty_step(input logic [CODE_BITS-1:0] tc,
                                             input logic [CODE_BITS-1:0] amb);
    u64_t         scaled;
    u64_t         quot;
    u64_t         biased;
    longint       temp_q8;
    longint       err_q8;
    longint       incr;
    longint       drive;
    loop_result_t r;
    scaled  = u64_t'(tc) * TC_Q24 + u64_t'(amb) * AMB_Q24;
    quot    = (scaled + FULL_SCALE / 2) / FULL_SCALE;
    biased  = quot + (BIAS_Q8 << 16) - OFFSET_Q24 + 64'd32768;
    temp_q8 = longint'(biased >> 16) - longint'(BIAS_Q8);
    err_q8  = longint'(setpoint_q8) - temp_q8;
    incr    = longint'(gain_now) * err_q8 + longint'(gain_prev) * longint'(held_error);
    drive   = ((incr + 64'sd32768) >>> 16) + longint'(prev_duty);
    if (drive < 0) begin
      drive = 0;
    end else if (drive > DUTY_FULL) begin
      drive = DUTY_FULL;
    end
    prev_duty  = drive[DUTY_W-1:0];
    held_error = err_q8[ERR_W-1:0];
    r.duty = drive[DUTY_W-1:0];
    r.temp = temp_q8[TEMP_W-1:0];
    r.err  = err_q8[ERR_W-1:0];
    return r;
  endfunction

  // watch all channels at the rising edge
  always @(posedge clk) begin
    loop_result_t got;
    loop_result_t want;
    if (rst) begin
      setpoint_q8 = 17'd19200;
      gain_now    = 24'sd708968;
      gain_prev   = -24'sd1180;
      held_error  = '0;
      prev_duty   = '0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETPOINT:      setpoint_q8 = cfg_data[SETPOINT_W-1:0];
          REG_GAIN_CURRENT:  gain_now    = cfg_data[GAIN_W-1:0];
          REG_GAIN_PREVIOUS: gain_prev   = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      // result transfer
      if (m_tvalid && m_tready) begin
        got.duty = m_tdata[14:0];
        got.temp = m_tdata[31:15];
        got.err  = m_tdata[50:32];
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: duty_percent %0d", got.duty);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty_percent: expected %0d, actual %0d", want.duty, got.duty);
            fail_count++;
          end
          if (got.temp !== want.temp) begin
            $error("measured_temperature: expected %0d, actual %0d", want.temp, got.temp);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $error("control_error: expected %0d, actual %0d", want.err, got.err);
            fail_count++;
          end
        end
      end
      // sample transfer
      if (s_tvalid && s_tready) begin
        expected_results.push_back(duty_step(s_tdata[CODE_BITS-1:0],
                                             s_tdata[2*CODE_BITS-1:CODE_BITS]));
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the temperature PI duty controller.
// ----------------------------------------------------------------------------
// Drives sample pairs with random gaps and random output back-pressure,
// starting with corner codes and register extremes, then runs random phases
// with wild, tracking and default loop settings. Registers change only once
// every result is back. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench import tpdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_BITS    = 10;
  localparam int IN_W         = ((2 * CODE_BITS + 7) / 8) * 8;
  localparam int CODE_MAX     = (1 << CODE_BITS) - 1;
  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 105;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   steady;
  int                     fail_count;
  int                     pending;
  int                     cycle_count;

  temperature_pi_duty_controller #(.CODE_BITS(CODE_BITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpdc_loop_checker #(.CODE_BITS(CODE_BITS), .IN_W(IN_W)) result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // one sample transfer, entered and left at a falling edge with s_tvalid high
  task automatic send_codes(input int tc, input int amb);
    while (!steady && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 2 * CODE_BITS){1'b0}},
                 CODE_BITS'(amb), CODE_BITS'(tc)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write, leaves cfg_valid high
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_loop(input logic [CFG_DATA_W-1:0] sp_word,
                              input logic [CFG_DATA_W-1:0] gc,
                              input logic [CFG_DATA_W-1:0] gp);
    write_reg(REG_SETPOINT, sp_word);
    write_reg(REG_GAIN_CURRENT, gc);
    write_reg(REG_GAIN_PREVIOUS, gp);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every result come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int phase;
    int k;
    int profile;
    int tc_mid;
    int amb_mid;
    int tc;
    int amb;
    int gc;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner codes with reset settings, cold start drives to full duty
    send_codes(0, 0);
    send_codes(0, 0);
    send_codes(CODE_MAX, CODE_MAX);
    send_codes(CODE_MAX, CODE_MAX);
    send_codes(0, CODE_MAX);
    send_codes(CODE_MAX, 0);
    send_codes(10'h155, 10'h2AA);
    send_codes(10'h2AA, 10'h155);
    send_codes(512, 512);
    send_codes(1, 1);
    send_codes(CODE_MAX - 1, CODE_MAX - 1);
    send_codes(0, 0);
    settle();

    // unused index is ignored; setpoint above range, gain extremes
    write_reg(REG_UNUSED, 24'hFFFFFF);
    program_loop(24'd131071, 24'h7FFFFF, 24'h800000);
    send_codes(0, 0);
    send_codes(CODE_MAX, CODE_MAX);
    send_codes(0, 0);
    send_codes(512, 300);
    settle();
    program_loop(24'd0, 24'h800000, 24'h7FFFFF);
    send_codes(CODE_MAX, CODE_MAX);
    send_codes(0, 0);
    send_codes(CODE_MAX, 0);
    settle();
    program_loop(24'd128000, 24'd0, 24'd0);
    send_codes(0, CODE_MAX);
    send_codes(300, 700);
    settle();

    // random phases over several loop settings
    for (phase = 0; phase < PHASES; phase++) begin
      profile = phase % 3;
      steady  = (phase == 4);
      case (profile)
        0: program_loop(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                        CFG_DATA_W'($urandom()));
        1: begin
          gc = $urandom_range(20000);
          program_loop(CFG_DATA_W'($urandom_range(128000)), CFG_DATA_W'(gc),
                       CFG_DATA_W'(-int'($urandom_range(gc))));
        end
        default: program_loop(CFG_DATA_W'(19200 + $urandom_range(2560)),
                              CFG_DATA_W'(GAIN_CURRENT_RST),
                              CFG_DATA_W'(GAIN_PREVIOUS_RST));
      endcase
      tc_mid  = $urandom_range(CODE_MAX);
      amb_mid = $urandom_range(CODE_MAX);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (profile == 1) begin
          // hover around an operating point with small code steps
          tc  = tc_mid + int'($urandom_range(12)) - 6;
          amb = amb_mid + int'($urandom_range(12)) - 6;
          tc  = (tc < 0) ? 0 : ((tc > CODE_MAX) ? CODE_MAX : tc);
          amb = (amb < 0) ? 0 : ((amb > CODE_MAX) ? CODE_MAX : amb);
        end else begin
          tc  = $urandom_range(CODE_MAX);
          amb = $urandom_range(CODE_MAX);
        end
        send_codes(tc, amb);
      end
      settle();
    end

    // verdict
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
